### rtl/core/pdpd_pkg.sv
// Shared types, codes and tables for the pixel detector packet decoder.
package pdpd_pkg;

  // Record kinds on the result channel
  typedef enum logic [2:0] {
    KIND_TDC          = 3'd0,
    KIND_PIXEL        = 3'd1,
    KIND_GLOBAL_TIME  = 3'd2,
    KIND_READOUT_CTRL = 3'd3,
    KIND_CHIP_CTRL    = 3'd4,
    KIND_STRAY        = 3'd5
  } kind_e;

  // Top-nibble record codes inside a chunk
  localparam logic [3:0] NIB_GLOBAL_TIME  = 4'h4;
  localparam logic [3:0] NIB_READOUT_CTRL = 4'h5;
  localparam logic [3:0] NIB_TDC          = 4'h6;
  localparam logic [3:0] NIB_CHIP_CTRL    = 4'h7;
  localparam logic [3:0] NIB_PIXEL        = 4'hB;

  // Global time subtypes
  localparam logic [7:0] GT_SUB_LOW  = 8'h44;
  localparam logic [7:0] GT_SUB_HIGH = 8'h45;

  // Chunk header signature in the low 32 bits of a word
  localparam logic [31:0] CHUNK_SIGNATURE = 32'h3358_5054;

  // Field widths
  localparam int unsigned WordW      = 64;
  localparam int unsigned LimitW     = 32;
  localparam int unsigned ChunkW     = 16;
  localparam int unsigned WordsLeftW = 13;
  localparam int unsigned TdcQW      = 9;

  // TDC fine correction: low 9 bits of ((f - 1) * 512) / 12, modulo 2^64
  function automatic logic [TdcQW-1:0] tdc_fine_q(input logic [3:0] f);
    logic [TdcQW-1:0] q;
    case (f)
      4'd0:    q = 9'd298;
      4'd1:    q = 9'd0;
      4'd2:    q = 9'd42;
      4'd3:    q = 9'd85;
      4'd4:    q = 9'd128;
      4'd5:    q = 9'd170;
      4'd6:    q = 9'd213;
      4'd7:    q = 9'd256;
      4'd8:    q = 9'd298;
      4'd9:    q = 9'd341;
      4'd10:   q = 9'd384;
      4'd11:   q = 9'd426;
      4'd12:   q = 9'd469;
      4'd13:   q = 9'd0;
      4'd14:   q = 9'd42;
      default: q = 9'd85;
    endcase
    return q;
  endfunction

endpackage

### rtl/core/pixel_detector_packet_decoder.sv
// Pixel detector packet decoder: chunk tracking, record decode and result register.
//
//   channel  | handshake              | payload
//   ---------+------------------------+-----------------------------------------------
//   input    | in_valid_i / in_stall_o | packet_word_i
//   result   | out_valid_o / out_stall_i | kind_o, chunk_number_o, pixel_x_o, pixel_y_o,
//            |                        | time_ticks_o, aux_value_o, header_in_chunk_o
//   config   | cfg_we_i               | cfg_wdata_i (word limit)
//
// One beat per cycle unless stalled; a result shows in the cycle after its beat is taken.
// The chunk state and counters update in the cycle the beat is taken, set by
// a 32-bit increment, a 33-bit add and a compare against the word limit.
// rst_ni clears chunk state, counters, word limit, out_valid_o; chunk index resets to 1.
// in_stall_o is high only while a result waits and out_stall_i holds it.
module pixel_detector_packet_decoder (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [pdpd_pkg::LimitW-1:0]          cfg_wdata_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [pdpd_pkg::WordW-1:0]           packet_word_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output pdpd_pkg::kind_e                      kind_o,
  output logic [pdpd_pkg::ChunkW-1:0]          chunk_number_o,
  output logic [7:0]                           pixel_x_o,
  output logic [7:0]                           pixel_y_o,
  output logic [pdpd_pkg::WordW-1:0]           time_ticks_o,
  output logic [15:0]                          aux_value_o,
  output logic                                 header_in_chunk_o
);
  import pdpd_pkg::*;

  // State
  logic [LimitW-1:0]     word_limit_q;
  logic                  inside_q, inside_d;
  logic [WordsLeftW-1:0] words_left_q, words_left_d;
  logic [ChunkW-1:0]     chunk_idx_q, chunk_idx_d;
  logic [LimitW-1:0]     words_seen_q, words_seen_d;
  logic [LimitW-1:0]     words_proc_q, words_proc_d;

  // Result register
  logic                  out_valid_q;
  kind_e                 kind_q;
  logic [ChunkW-1:0]     chunk_num_q;
  logic [7:0]            pix_x_q, pix_y_q;
  logic [WordW-1:0]      time_q;
  logic [15:0]           aux_q;
  logic                  hdr_q;

  // Decode signals
  logic                  load_out, accept;
  logic                  limit_on, limit_hit;
  logic                  is_sig;
  logic [3:0]            nib;
  logic [7:0]            gt_sub;
  logic                  has_res;
  kind_e                 kind_d;
  logic [7:0]            pix_x_d, pix_y_d;
  logic [WordW-1:0]      time_d;
  logic [15:0]           aux_d;
  logic [LimitW-1:0]     proc_inc;
  logic [LimitW:0]       hdr_sum;
  logic [LimitW-1:0]     clip_n;
  logic [WordsLeftW-1:0] hdr_len;
  logic                  hdr_empty;
  logic [WordsLeftW-1:0] left_dec;
  logic                  close_chunk;

  // Handshake: take a beat whenever the result register is free or draining
  assign load_out   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !load_out;
  assign accept     = in_valid_i && load_out;

  assign limit_on  = (word_limit_q != '0);
  assign limit_hit = limit_on && (words_seen_q >= word_limit_q);
  assign is_sig    = (packet_word_i[31:0] == CHUNK_SIGNATURE);
  assign nib       = packet_word_i[63:60];
  assign gt_sub    = packet_word_i[63:56];

  // Decode the record fields from the word
  always_comb begin
    kind_d  = KIND_STRAY;
    pix_x_d = '0;
    pix_y_d = '0;
    time_d  = '0;
    aux_d   = '0;
    has_res = 1'b0;
    if (!inside_q) begin
      has_res = !is_sig;
    end else begin
      case (nib)
        NIB_PIXEL: begin
          has_res = 1'b1;
          kind_d  = KIND_PIXEL;
          pix_x_d = {packet_word_i[59:53], packet_word_i[46]};
          pix_y_d = {packet_word_i[52:47], packet_word_i[45:44]};
          time_d  = {22'd0, packet_word_i[15:0], packet_word_i[43:30],
                     ~packet_word_i[19:16], 8'd0};
          aux_d   = {6'd0, packet_word_i[29:20]};
        end
        NIB_TDC: begin
          has_res = 1'b1;
          kind_d  = KIND_TDC;
          time_d  = {20'd0, packet_word_i[43:12], packet_word_i[11:9],
                     tdc_fine_q(packet_word_i[8:5])};
        end
        NIB_GLOBAL_TIME: begin
          has_res = 1'b1;
          kind_d  = KIND_GLOBAL_TIME;
          if (gt_sub == GT_SUB_LOW) begin
            time_d = {20'd0, packet_word_i[47:16], 12'd0};
            aux_d  = packet_word_i[15:0];
          end else if (gt_sub == GT_SUB_HIGH) begin
            // v * (2^44 - 2^16)
            time_d = {4'd0, packet_word_i[31:16], 44'd0}
                   - {32'd0, packet_word_i[31:16], 16'd0};
            aux_d  = packet_word_i[15:0];
          end
        end
        NIB_READOUT_CTRL: begin
          has_res = 1'b1;
          kind_d  = KIND_READOUT_CTRL;
        end
        NIB_CHIP_CTRL: begin
          has_res = 1'b1;
          kind_d  = KIND_CHIP_CTRL;
        end
        default: begin
          has_res = 1'b0;
        end
      endcase
    end
    if (limit_hit) begin
      has_res = 1'b0;
    end
  end

  // Header length, clipped against the word limit
  assign proc_inc  = words_proc_q + 1'b1;
  assign hdr_sum   = {1'b0, proc_inc} + {20'd0, packet_word_i[63:51]};
  assign clip_n    = word_limit_q - proc_inc;
  always_comb begin
    if (limit_on && (hdr_sum > {1'b0, word_limit_q})) begin
      hdr_len   = clip_n[WordsLeftW-1:0];
      hdr_empty = (clip_n == '0);
    end else begin
      hdr_len   = packet_word_i[63:51];
      hdr_empty = (packet_word_i[63:51] == '0);
    end
  end

  // Chunk slot accounting
  assign left_dec = (words_left_q != '0) ? words_left_q - 1'b1 : '0;

  always_comb begin
    inside_d     = inside_q;
    words_left_d = words_left_q;
    chunk_idx_d  = chunk_idx_q;
    words_seen_d = words_seen_q;
    words_proc_d = words_proc_q;
    close_chunk  = 1'b0;
    if (accept && !limit_hit) begin
      words_seen_d = words_seen_q + 1'b1;
      if (!inside_q) begin
        if (is_sig) begin
          words_proc_d = proc_inc;
          if (hdr_empty) begin
            close_chunk = 1'b1;
          end else begin
            inside_d     = 1'b1;
            words_left_d = hdr_len;
          end
        end
      end else begin
        if (has_res) begin
          words_proc_d = proc_inc;
        end
        words_left_d = left_dec;
        close_chunk  = (left_dec == '0)
                    || (limit_on && (words_proc_d >= word_limit_q));
      end
      if (close_chunk) begin
        inside_d     = 1'b0;
        words_left_d = '0;
        chunk_idx_d  = chunk_idx_q + 1'b1;
      end
    end
  end

  // Hold state and the word limit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_limit_q <= '0;
      inside_q     <= 1'b0;
      words_left_q <= '0;
      chunk_idx_q  <= ChunkW'(1);
      words_seen_q <= '0;
      words_proc_q <= '0;
    end else begin
      if (cfg_we_i) begin
        word_limit_q <= cfg_wdata_i;
      end
      inside_q     <= inside_d;
      words_left_q <= words_left_d;
      chunk_idx_q  <= chunk_idx_d;
      words_seen_q <= words_seen_d;
      words_proc_q <= words_proc_d;
    end
  end

  // Result valid: load on a taken beat, drop once delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= accept && has_res;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (accept && has_res) begin
      kind_q      <= kind_d;
      chunk_num_q <= chunk_idx_q;
      pix_x_q     <= pix_x_d;
      pix_y_q     <= pix_y_d;
      time_q      <= time_d;
      aux_q       <= aux_d;
      hdr_q       <= inside_q && is_sig;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign kind_o            = kind_q;
  assign chunk_number_o    = chunk_num_q;
  assign pixel_x_o         = pix_x_q;
  assign pixel_y_o         = pix_y_q;
  assign time_ticks_o      = time_q;
  assign aux_value_o       = aux_q;
  assign header_in_chunk_o = hdr_q;

  // Checks
  a_closed_no_slots: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !inside_q |-> (words_left_q == '0))
    else $error("words left nonzero outside a chunk");

  a_limit_freezes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && limit_hit && !cfg_we_i) |=> $stable(words_seen_q) && !out_valid_q)
    else $error("word past the limit changed state or gave a result");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_stall_i && !(in_valid_i && has_res)) |=> !out_valid_q)
    else $error("delivered result not dropped");

  a_stray_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (kind_q == KIND_STRAY)) |-> ((time_q == '0) && !hdr_q))
    else $error("stray record carries payload");

  a_proc_not_on_stray: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !inside_q && !is_sig) |=> $stable(words_proc_q))
    else $error("stray word counted as processed");

endmodule
